// File: design/gsec_pkg.sv
package gsec_pkg;

	localparam int SAMPLE_W = 15;
	localparam int VOLT_W   = 30;
	localparam int PPM_W    = 16;
	localparam int LVL_W    = 8;
	localparam int MV_W     = 13;

	localparam logic [VOLT_W-1:0] OFFSET_RESET = 30'(1500 * 65536);
	localparam logic [VOLT_W-1:0] MV_600_Q16   = 30'(600 * 65536);
	localparam logic [27:0]       LOG2_400_Q24 = 28'd145019842;
	localparam int                CURVE_DIV_SH = 24;

	localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;
	localparam logic [0:0] REG_SMOOTHING    = 1'b1;

	// 2^(i/256) in Q1.16
	function automatic logic [16:0] exp_frac(input logic [7:0] i);
		logic [63:0] acc;
		logic [15:0] f;
		logic [31:0] r;
		acc = 64'd1 << 30;
		f = {i, 8'd0};
		for (int k = 0; k < 16; k++) begin
			case (k)
				0: r = 32'd1518500250;  1: r = 32'd1276901417;
				2: r = 32'd1170923762;  3: r = 32'd1121280436;
				4: r = 32'd1097253708;  5: r = 32'd1085434106;
				6: r = 32'd1079572136;  7: r = 32'd1076653033;
				8: r = 32'd1075196443;  9: r = 32'd1074468888;
				10: r = 32'd1074105294; 11: r = 32'd1073923544;
				12: r = 32'd1073832680; 13: r = 32'd1073787251;
				14: r = 32'd1073764537; default: r = 32'd1073753181;
			endcase
			if (f[15-k])
				acc = (acc * {32'd0, r} + (64'd1 << 29)) >> 30;
		end
		return 17'((acc + 64'd8192) >> 14);
	endfunction

	typedef logic [255:0][16:0] exp_tab_t;

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = exp_frac(8'(i));
		return t;
	endfunction

	// constant 2^x fraction table, folded at elaboration
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIV  = 8'b0000_0010,
		ST_MIX  = 8'b0000_0100,
		ST_LOG  = 8'b0000_1000,
		ST_CDIV = 8'b0001_0000,
		ST_EXP  = 8'b0010_0000,
		ST_LVL  = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

endpackage

// File: design/gas_sensor_ema_exp_converter_core.sv
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_ready  | sample[14:0], action
// out     | out       | out_valid/out_ready| ppm, green_level, red_level, voltage_mv, calibrated
// cfg     | in        | APB psel/penable   | sample_count, smoothing_weight
// A discarded or summed (non-final) sample is taken without leaving the idle state.
// A final sample passes through a 58-bit serial divide for the average, two
// 17-bit shift-add multiplies for the blend, a set-up state, a 58-bit serial
// divide for the exponent, then lookup and level stages. The two dividers
// dominate the latency; input reopens after the output state.
// Reset restores the offset to 1500 mV; the 2^x table is constant logic.
// One result is held in an output register; the next sample is taken meanwhile
// only if it does not complete a reading.
module gas_sensor_ema_exp_converter_core #(
	parameter int MAX_SAMPLES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [gsec_pkg::SAMPLE_W-1:0] sample,
	input  logic                          action,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gsec_pkg::PPM_W-1:0]    ppm,
	output logic [gsec_pkg::LVL_W-1:0]    green_level,
	output logic [gsec_pkg::LVL_W-1:0]    red_level,
	output logic [gsec_pkg::MV_W-1:0]     voltage_mv,
	output logic                          calibrated,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import gsec_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES + 1);

	state_t state_q;
	logic [4:0]        count_cfg_q;
	logic [15:0]       weight_q;
	logic [CNT_W-1:0]  pos_q;
	logic [SUM_W-1:0]  sum_q;
	logic [VOLT_W-1:0] volt_q, offset_q;
	logic              act_q;
	logic [CNT_W-1:0]  eff_cnt;

	// shift-add multiplier accumulator
	logic [47:0] acc_q;
	logic [31:0] mcand_q;
	logic [16:0] mplier_q;
	logic [4:0]  mcnt_q;
	logic        mphase_q;

	logic [57:0] dnum;
	logic [33:0] dden;
	logic        dstart, ddone;
	logic [57:0] dquo;

	logic [11:0] y_q;      // exponent bits 19:8 (Q16)
	logic        yneg_q;
	logic        ysat_q;
	logic [15:0] ppm_q;
	logic [7:0]  green_q;
	logic [15:0] ppm_calc;
	logic        acc_w;

	assign pready = 1'b1;
	assign acc_w  = psel && penable && pwrite;
	always_comb begin
		case (paddr[2])
			REG_SAMPLE_COUNT: prdata = {27'd0, count_cfg_q};
			default:          prdata = {16'd0, weight_q};
		endcase
	end

	always_comb begin
		if (count_cfg_q == 5'd0)
			eff_cnt = CNT_W'(1);
		else if (32'(count_cfg_q) > MAX_SAMPLES)
			eff_cnt = CNT_W'(MAX_SAMPLES);
		else
			eff_cnt = CNT_W'(count_cfg_q);
	end

	logic in_fire, final_smp;
	assign final_smp = (pos_q != '0) && (32'(pos_q) >= 32'(eff_cnt));
	assign in_ready  = (state_q == ST_IDLE) && !(final_smp && out_valid);
	assign in_fire   = in_valid && in_ready;

	gsec_serdiv #(.NUM_W(58), .DEN_W(34)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	// diff and its magnitude product
	logic [VOLT_W:0] diff;
	logic [VOLT_W-1:0] dmag;
	assign diff = {1'b0, offset_q} - {1'b0, volt_q};
	assign dmag = diff[VOLT_W] ? VOLT_W'(-diff) : diff[VOLT_W-1:0];

	// exponent to ppm: integer part shifts the table entry
	logic [3:0]  ip;
	logic [16:0] mval;
	always_comb begin
		ip       = y_q[11:8];
		mval     = EXP_TAB[y_q[7:0]];
		ppm_calc = 16'(mval >> (5'd16 - 5'(ip)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_cfg_q <= 5'd3;
			weight_q    <= 16'd64881;
			pos_q       <= '0;
			volt_q      <= '0;
			offset_q    <= OFFSET_RESET;
			out_valid   <= 1'b0;
			mphase_q    <= 1'b0;
			mcnt_q      <= '0;
		end else begin
			if (acc_w) begin
				case (paddr[2])
					REG_SAMPLE_COUNT: count_cfg_q <= pwdata[4:0];
					default:          weight_q    <= pwdata[15:0];
				endcase
			end
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (pos_q == '0) begin
							pos_q <= CNT_W'(1);
						end else if (!final_smp) begin
							pos_q <= pos_q + 1'b1;
						end else begin
							pos_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: if (ddone) begin
					mphase_q <= 1'b0;
					mcnt_q   <= 5'd17;
					state_q  <= ST_MIX;
				end
				ST_MIX: begin
					if (mcnt_q != 5'd0) begin
						mcnt_q <= mcnt_q - 1'b1;
					end else if (!mphase_q) begin
						mphase_q <= 1'b1;
						mcnt_q   <= 5'd17;
					end else begin
						volt_q  <= acc_q[45:16];
						state_q <= ST_LOG;
					end
				end
				ST_LOG:  state_q <= ST_CDIV;
				ST_CDIV: if (ddone) state_q <= ST_EXP;
				ST_EXP:  state_q <= ST_LVL;
				ST_LVL: begin
					if (act_q)
						offset_q <= volt_q + MV_600_Q16;
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_OUT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	logic [57:0] prod_d;
	assign prod_d = 58'(dmag) * 58'(LOG2_400_Q24);
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				sum_q <= (pos_q == '0) ? '0 : sum_q + SUM_W'(sample);
				act_q <= action;
			end
			ST_DIV: begin
				if (ddone) begin
					acc_q    <= '0;
					mcand_q  <= 32'(dquo);
					mplier_q <= 17'h10000 - {1'b0, weight_q};
				end
			end
			ST_MIX: begin
				if (mcnt_q != 5'd0) begin
					if (mplier_q[0])
						acc_q <= acc_q + (48'(mcand_q) << (5'd17 - mcnt_q));
					mplier_q <= mplier_q >> 1;
				end else if (!mphase_q) begin
					mcand_q  <= 32'(volt_q);
					mplier_q <= {1'b0, weight_q};
				end
			end
			ST_CDIV: if (ddone) begin
				// negative difference gives ppm 0, y of 16 or more saturates
				yneg_q <= diff[VOLT_W];
				ysat_q <= (dquo[57:20] != '0);
				y_q    <= dquo[19:8];
			end
			ST_EXP: begin
				if (yneg_q)
					ppm_q <= 16'd0;
				else if (ysat_q)
					ppm_q <= 16'hFFFF;
				else
					ppm_q <= ppm_calc;
			end
			ST_LVL: begin
				ppm       <= act_q ? 16'd400 : ppm_q;
				green_level <= green_q;
				red_level <= 8'd255 - green_q;
				voltage_mv <= volt_q[28:16];
				calibrated <= act_q;
			end
			default: ;
		endcase
	end

	// green level, divide by 400 as reciprocal: 255 * ceil(2^26 / 400)
	logic [8:0]  gdiff;
	logic [34:0] gprod;
	always_comb begin
		gdiff = 9'(ppm_q - 16'd600);
		gprod = 35'(gdiff) * 35'd42782115;
		if (ppm_q < 16'd600)
			green_q = 8'd255;
		else if (ppm_q > 16'd1000)
			green_q = 8'd0;
		else
			green_q = 8'd255 - 8'(gprod >> 26);
	end

	always_comb begin
		dstart = 1'b0;
		dnum   = '0;
		dden   = '0;
		if (state_q == ST_IDLE && in_fire && final_smp) begin
			dstart = 1'b1;
			dnum   = 58'(sum_q + SUM_W'(sample)) * 58'd12288;
			dden   = 34'(pos_q);
		end else if (state_q == ST_LOG) begin
			dstart = 1'b1;
			dnum   = prod_d >> CURVE_DIV_SH;
			dden   = 34'd600;
		end
	end

	ap_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calibrated && $rose(out_valid) |-> ppm == 16'd400)
		else $error("calibrating beat without 400 ppm");
	ap_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (green_level + red_level) == 8'd255)
		else $error("levels not complementary");
	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("input taken while busy");

endmodule

// File: design/gsec_serdiv.sv
module gsec_serdiv #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	// restoring divider, one quotient bit per cycle
	localparam int CW = $clog2(NUM_W + 1);
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;

endmodule

// File: tb/tb_gas_sensor_ema_exp_converter_core.sv
`timescale 1ns / 1ps

module tb_gas_sensor_ema_exp_converter_core;
	import gsec_pkg::*;

	localparam int MAX_SAMPLES = 16;
	localparam int TABLE_DEPTH = 256;
	// settle margin after draining, beyond the block's processing of a final sample
	localparam int SETTLE_CYCLES = 400;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                action;
	} adc_beat_t;

	typedef struct packed {
		logic [PPM_W-1:0] ppm;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] red;
		logic [MV_W-1:0]  mv;
		logic             calibrated;
	} reading_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                action;
	logic                out_valid;
	logic                out_ready;
	logic [PPM_W-1:0]    ppm;
	logic [LVL_W-1:0]    green_level;
	logic [LVL_W-1:0]    red_level;
	logic [MV_W-1:0]     voltage_mv;
	logic                calibrated;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	gas_sensor_ema_exp_converter_core #(.MAX_SAMPLES(MAX_SAMPLES)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .action(action),
		.out_valid(out_valid), .out_ready(out_ready), .ppm(ppm),
		.green_level(green_level), .red_level(red_level), .voltage_mv(voltage_mv),
		.calibrated(calibrated),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state, mirrors the block
	logic [4:0]  cnt_reg;
	logic [15:0] weight_reg;
	logic [4:0]  burst_pos;
	logic [19:0] acc_sum;
	logic [29:0] v_smooth;
	logic [29:0] v_offset;
	logic [16:0] pow2_frac [TABLE_DEPTH];

	adc_beat_t pending_beats[$];
	reading_t  expected_readings[$];
	int        n_errors;

	// Q30 constants 2^(2^-(k+1)), k = 0..15
	function automatic logic [31:0] root_q30(input int k);
		case (k)
			0: return 32'd1518500250;  1: return 32'd1276901417;
			2: return 32'd1170923762;  3: return 32'd1121280436;
			4: return 32'd1097253708;  5: return 32'd1085434106;
			6: return 32'd1079572136;  7: return 32'd1076653033;
			8: return 32'd1075196443;  9: return 32'd1074468888;
			10: return 32'd1074105294; 11: return 32'd1073923544;
			12: return 32'd1073832680; 13: return 32'd1073787251;
			14: return 32'd1073764537; default: return 32'd1073753181;
		endcase
	endfunction

	task automatic build_pow2_table();
		logic [63:0] a;
		logic [15:0] f;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			a = 64'd1 << 30;
			f = 16'((i * 65536) / TABLE_DEPTH);
			for (int k = 0; k < 16; k++)
				if (f[15-k])
					a = (a * {32'd0, root_q30(k)} + (64'd1 << 29)) >> 30;
			pow2_frac[i] = 17'((a + 64'd8192) >> 14);
		end
	endtask

	function automatic longint floor_div(input longint num, input longint den);
		if (num >= 0)
			return num / den;
		return -((-num + den - 1) / den);
	endfunction

	// one accepted beat through the converter; returns 1 when a reading completes
	function automatic bit convert_beat(input adc_beat_t b, output reading_t r);
		int unsigned eff, n, avg, pp, gr;
		longint      mix, diff, y, ip, frac, idx;
		eff = (cnt_reg == 0) ? 1 : (cnt_reg > MAX_SAMPLES) ? MAX_SAMPLES : cnt_reg;
		if (burst_pos == 0) begin
			burst_pos = 1;
			acc_sum = 0;
			return 0;
		end
		acc_sum = acc_sum + 20'(b.sample);
		if (burst_pos < eff) begin
			burst_pos++;
			return 0;
		end
		n = burst_pos;
		burst_pos = 0;
		avg = int'((longint'(acc_sum) * 12288) / n);
		mix = (65536 - longint'(weight_reg)) * avg + longint'(weight_reg) * v_smooth;
		v_smooth = 30'(mix >> 16);
		diff = longint'(v_offset) - longint'(v_smooth);
		y = floor_div(diff * 145019842, 600 * 64'd16777216);
		ip = floor_div(y, 65536);
		frac = y - ip * 65536;
		if (ip < 0)
			pp = 0;
		else if (ip >= 16)
			pp = 65535;
		else begin
			idx = (frac * TABLE_DEPTH) >> 16;
			if (idx >= TABLE_DEPTH)
				idx = TABLE_DEPTH - 1;
			pp = pow2_frac[idx] >> (16 - ip);
			if (pp > 65535)
				pp = 65535;
		end
		if (pp < 600)
			gr = 255;
		else if (pp > 1000)
			gr = 0;
		else
			gr = 255 - ((pp - 600) * 255) / 400;
		if (b.action) begin
			v_offset = v_smooth + MV_600_Q16;
			pp = 400;
		end
		r.ppm = 16'(pp);
		r.green = 8'(gr);
		r.red = 8'(255 - gr);
		r.mv = 13'(v_smooth >> 16);
		r.calibrated = b.action;
		return 1;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// clock: 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// acceptance flag captured at the rising edge for the driver
	logic in_ready_q;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_ready_q <= 1'b0;
		else
			in_ready_q <= in_valid && in_ready;
	end

	// sender: bursts of random length separated by random gaps
	int burst_left;
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			action <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else if (!in_valid || in_ready_q) begin
			// previous beat (if any) went at the last rising edge
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				in_valid <= 1'b1;
				{sample, action} <= pending_beats.pop_front();
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else
					burst_left--;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver stall pattern: long open stretches, then choppy phases
	int stall_phase;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase = 0;
		end else begin
			stall_phase = (stall_phase + 1) % 600;
			if (stall_phase < 200)
				out_ready <= 1'b1;
			else if (stall_phase < 400)
				out_ready <= ($urandom_range(0, 3) != 0);
			else
				out_ready <= ($urandom_range(0, 7) == 0);
		end
	end

	// input monitor feeds the predictor; output monitor checks readings
	always @(posedge clk) begin
		reading_t r;
		reading_t e;
		if (arst_n && in_valid && in_ready)
			if (convert_beat('{sample: sample, action: action}, r))
				expected_readings.push_back(r);
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0)
				report_mismatch("unexpected reading", 1, 0);
			else begin
				e = expected_readings.pop_front();
				if (ppm !== e.ppm)
					report_mismatch("ppm", ppm, e.ppm);
				if (green_level !== e.green)
					report_mismatch("green_level", green_level, e.green);
				if (red_level !== e.red)
					report_mismatch("red_level", red_level, e.red);
				if (voltage_mv !== e.mv)
					report_mismatch("voltage_mv", voltage_mv, e.mv);
				if (calibrated !== e.calibrated)
					report_mismatch("calibrated", calibrated, e.calibrated);
			end
		end
	end

	// APB write: setup then access, driven on falling edges
	task automatic apb_write(input logic [0:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_SAMPLE_COUNT)
			cnt_reg = val[4:0];
		else
			weight_reg = val[15:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain_and_settle();
		while (pending_beats.size() != 0 || in_valid || expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one complete reading: discarded beat, then cnt counted beats
	task automatic queue_reading(input int cnt, input bit cal, input bit rnd_extreme);
		adc_beat_t b;
		for (int i = 0; i <= cnt; i++) begin
			b.sample = rnd_extreme ? ($urandom_range(0, 1) ? '1 : '0) : SAMPLE_W'($urandom);
			// action only matters on the last beat; randomise the rest
			b.action = (i == cnt) ? cal : 1'($urandom_range(0, 1));
			pending_beats.push_back(b);
		end
	endtask

	initial begin
		int eff;
		int items;
		logic [4:0] cnt_set [6];
		logic [15:0] w_set [6];
		cnt_set = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd7};
		w_set = '{16'd0, 16'd65535, 16'd32768, 16'd64881, 16'd1000, 16'd50000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		action = 1'b0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		n_errors = 0;
		cnt_reg = 5'd3;
		weight_reg = 16'd64881;
		burst_pos = '0;
		acc_sum = '0;
		v_smooth = '0;
		v_offset = OFFSET_RESET;
		build_pow2_table();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, full scale and zero samples, calibrate, recover
		pending_beats.push_back('{sample: 15'h7fff, action: 1'b1});
		for (int i = 0; i < 3; i++)
			pending_beats.push_back('{sample: 15'h7fff, action: 1'b0});
		queue_reading(3, 1'b1, 1'b0);
		queue_reading(3, 1'b0, 1'b1);
		for (int i = 0; i < 4; i++)
			pending_beats.push_back('{sample: 15'h0, action: 1'b0});
		drain_and_settle();

		// count lowered mid-burst: start a 16-sample burst, cut to 1
		apb_write(REG_SMOOTHING, 32'd0);
		apb_write(REG_SAMPLE_COUNT, 32'd16);
		for (int i = 0; i < 6; i++)
			pending_beats.push_back('{sample: SAMPLE_W'($urandom), action: 1'b0});
		drain_and_settle();
		apb_write(REG_SAMPLE_COUNT, 32'd1);
		pending_beats.push_back('{sample: 15'h1234, action: 1'b1});
		drain_and_settle();

		// random phases through several settings, extremes included
		items = 0;
		for (int ph = 0; items < 1250; ph++) begin
			if (ph < 6) begin
				apb_write(REG_SAMPLE_COUNT, {27'd0, cnt_set[ph]});
				apb_write(REG_SMOOTHING, {16'd0, w_set[ph]});
			end else begin
				apb_write(REG_SAMPLE_COUNT, ($urandom_range(0, 7) == 0) ?
					$urandom_range(17, 31) : $urandom_range(0, 5));
				apb_write(REG_SMOOTHING, ($urandom_range(0, 1)) ?
					$urandom_range(0, 65535) : $urandom_range(60000, 65535));
			end
			eff = (cnt_reg == 0) ? 1 : (cnt_reg > MAX_SAMPLES) ? MAX_SAMPLES : cnt_reg;
			for (int r = 0; r < 12; r++) begin
				if ($urandom_range(0, 9) == 0)
					// stray beats break burst alignment
					for (int i = 0; i < $urandom_range(1, 3); i++) begin
						pending_beats.push_back('{sample: SAMPLE_W'($urandom),
							action: 1'($urandom)});
						items++;
					end
				else begin
					queue_reading(eff, $urandom_range(0, 5) == 0, $urandom_range(0, 9) == 0);
					items += eff + 1;
				end
			end
			drain_and_settle();
		end
		if (n_errors == 0)
			$display("tb_gas_sensor_ema_exp_converter_core passed");
		else
			$display("tb_gas_sensor_ema_exp_converter_core failed");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(12 * 3000000);
		$display("tb_gas_sensor_ema_exp_converter_core failed");
		$finish;
	end

endmodule
